>>> sv/assert_macros.svh
// Assertion shorthands shared by the interval lookup modules.
// Expects clk and rst_n in the scope of the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define SIBL_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SIBL_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/sibl_pkg.sv
// Types and constants for the sorted interval lookup block.
// Used by every module of the block; has no dependencies.
package sibl_pkg;

    localparam int TABLE_ENTRIES_DEF = 4096;
    localparam int NUM_CHROMS_DEF    = 256;
    localparam int QUEUE_DEPTH       = 2;

    typedef enum logic [1:0] {
        OP_SLOT_WR  = 2'd0,
        OP_RANGE_WR = 2'd1,
        OP_LOOKUP   = 2'd2
    } op_t;

    // work kinds after classification
    typedef enum logic [1:0] {
        K_SLOT_WR  = 2'd0,
        K_RANGE_WR = 2'd1,
        K_LOOKUP   = 2'd2,
        K_MISS     = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_RANGE,
        BK_PROBE,
        BK_DONE
    } back_state_t;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [7:0]  chrom;
        logic [11:0] slot;
        logic [31:0] interval_begin;
        logic [31:0] interval_end;
        logic [31:0] bin_number;
        logic [11:0] range_first;
        logic [11:0] range_last;
        logic        chrom_present;
        logic [31:0] position;
    } req_word_t;

    typedef struct packed {
        logic        found;
        logic [31:0] found_bin;
        logic [11:0] found_slot;
    } rsp_word_t;

    typedef struct packed {
        logic        present;
        logic [11:0] first;
        logic [11:0] last;
    } range_entry_t;

    localparam int RANGE_W = $bits(range_entry_t);

    typedef struct packed {
        logic [31:0] ibeg;
        logic [31:0] iend;
        logic [31:0] ibin;
    } slot_entry_t;

    // queue word: addr is slot or chrom; arg0 holds a packed range, the position or the interval begin
    typedef struct packed {
        kind_t       kind;
        logic [11:0] addr;
        logic [31:0] arg0;
        logic [31:0] arg1;
        logic [31:0] arg2;
    } work_t;

    typedef struct packed {
        logic clearing;
    } back_status_t;

endpackage

>>> sv/sibl_queue.sv
// Two-entry queue of classified work words between front and back.
// Depends on sibl_pkg and assert_macros.svh.
`include "assert_macros.svh"

module sibl_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  sibl_pkg::work_t push_data,
    input  logic          pop,
    output sibl_pkg::work_t head,
    output logic          empty,
    output logic          full
);

    localparam int PW = $clog2(sibl_pkg::QUEUE_DEPTH);
    localparam int CW = $clog2(sibl_pkg::QUEUE_DEPTH + 1);

    sibl_pkg::work_t store [sibl_pkg::QUEUE_DEPTH];

    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == CW'(sibl_pkg::QUEUE_DEPTH));
    assign head  = store[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(sibl_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(sibl_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store[wr_ptr_reg] <= push_data;
        end
    end

    `SIBL_ASSERT_IMP(a_no_overflow, full && !pop, !push, "push into full queue")
    `SIBL_ASSERT_IMP(a_no_underflow, empty, !pop, "pop from empty queue")

endmodule

>>> sv/sibl_front.sv
// Front end: takes request words, drops no-ops and out-of-range writes
// and queues the rest. Depends on sibl_pkg.
module sibl_front #(
    parameter int TABLE_ENTRIES = sibl_pkg::TABLE_ENTRIES_DEF,
    parameter int NUM_CHROMS    = sibl_pkg::NUM_CHROMS_DEF
) (
    input  logic                   req_valid,
    output logic                   req_stall,
    input  sibl_pkg::req_word_t    req,
    input  sibl_pkg::back_status_t status,
    input  logic                   q_full,
    output logic                   push,
    output sibl_pkg::work_t        push_data
);

    logic keep;
    logic slot_ok;
    logic chrom_ok;
    sibl_pkg::range_entry_t rng;

    assign slot_ok  = (32'(req.slot) < 32'(TABLE_ENTRIES));
    assign chrom_ok = (32'(req.chrom) < 32'(NUM_CHROMS));

    always_comb
    begin
        rng.present = req.chrom_present;
        rng.first   = req.range_first;
        rng.last    = req.range_last;

        keep           = 1'b0;
        push_data.kind = sibl_pkg::K_MISS;
        push_data.addr = 12'(req.chrom);
        push_data.arg0 = req.position;
        push_data.arg1 = req.interval_end;
        push_data.arg2 = req.bin_number;
        case (req.opcode)
            sibl_pkg::OP_SLOT_WR:
            begin
                keep           = slot_ok;
                push_data.kind = sibl_pkg::K_SLOT_WR;
                push_data.addr = req.slot;
                push_data.arg0 = req.interval_begin;
            end
            sibl_pkg::OP_RANGE_WR:
            begin
                keep           = chrom_ok;
                push_data.kind = sibl_pkg::K_RANGE_WR;
                push_data.arg0 = 32'(rng);
            end
            sibl_pkg::OP_LOOKUP:
            begin
                // chrom beyond the table answers not found without a search
                keep           = 1'b1;
                push_data.kind = chrom_ok ? sibl_pkg::K_LOOKUP : sibl_pkg::K_MISS;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    assign req_stall = status.clearing || q_full;
    assign push      = req_valid && !req_stall && keep;

endmodule

>>> sv/sibl_back.sv
// Back end: interval and range tables, clearing pass and binary search engine.
// Depends on sibl_pkg and assert_macros.svh.
`include "assert_macros.svh"

module sibl_back #(
    parameter int TABLE_ENTRIES = sibl_pkg::TABLE_ENTRIES_DEF,
    parameter int NUM_CHROMS    = sibl_pkg::NUM_CHROMS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  sibl_pkg::work_t        q_head,
    input  logic                   q_empty,
    output logic                   pop,
    output sibl_pkg::back_status_t status,
    output logic                   rsp_valid,
    input  logic                   rsp_stall,
    output sibl_pkg::rsp_word_t    rsp
);

    localparam int SAW = $clog2(TABLE_ENTRIES);
    localparam int SW  = (SAW > 12) ? SAW : 12;
    localparam int CAW = (NUM_CHROMS > 1) ? $clog2(NUM_CHROMS) : 1;
    localparam int CW  = (CAW > 12) ? CAW : 12;

    sibl_pkg::slot_entry_t  slot_mem  [TABLE_ENTRIES];
    sibl_pkg::range_entry_t range_mem [NUM_CHROMS];

    sibl_pkg::back_state_t state_reg, state_next;
    logic [CAW-1:0] clr_cnt_reg, clr_cnt_next;
    logic           rsp_valid_reg, rsp_valid_next;
    sibl_pkg::rsp_word_t rsp_reg, rsp_next;

    logic [31:0] pos_reg, pos_next;
    logic [11:0] lo_reg, lo_next;
    logic [11:0] hi_reg, hi_next;
    logic [11:0] mid_reg, mid_next;
    logic        oob_reg, oob_next;
    sibl_pkg::rsp_word_t res_reg, res_next;

    sibl_pkg::slot_entry_t  slot_rd_reg;
    sibl_pkg::range_entry_t range_rd_reg;

    logic                   slot_we, slot_re;
    logic [SAW-1:0]         slot_waddr, slot_raddr;
    logic                   range_we, range_re;
    logic [CAW-1:0]         range_waddr, range_raddr;
    sibl_pkg::range_entry_t range_wdata;

    logic [SW-1:0]  slot_ext_w, slot_ext_r;
    logic [CW-1:0]  chrom_ext;
    logic [11:0]    lo_n, hi_n, mid_n;
    logic           probe;
    sibl_pkg::slot_entry_t probe_data;

    assign slot_ext_w = SW'(q_head.addr);
    assign chrom_ext  = CW'(q_head.addr);
    assign slot_ext_r = SW'(mid_n);
    assign slot_waddr = slot_ext_w[SAW-1:0];
    assign slot_raddr = slot_ext_r[SAW-1:0];
    assign mid_n      = 12'(({1'b0, lo_n} + {1'b0, hi_n}) >> 1);
    assign probe_data = oob_reg ? '0 : slot_rd_reg;

    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;
        pos_next       = pos_reg;
        res_next       = res_reg;
        lo_n           = lo_reg;
        hi_n           = hi_reg;
        probe          = 1'b0;
        pop            = 1'b0;
        slot_we        = 1'b0;
        range_we       = 1'b0;
        range_re       = 1'b0;
        range_waddr    = chrom_ext[CAW-1:0];
        range_raddr    = chrom_ext[CAW-1:0];
        range_wdata    = sibl_pkg::range_entry_t'(q_head.arg0[sibl_pkg::RANGE_W-1:0]);

        case (state_reg)
            sibl_pkg::BK_CLEAR:
            begin
                range_we     = 1'b1;
                range_waddr  = clr_cnt_reg;
                range_wdata  = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == CAW'(NUM_CHROMS - 1))
                begin
                    state_next = sibl_pkg::BK_IDLE;
                end
            end
            sibl_pkg::BK_IDLE:
            begin
                if (!q_empty)
                begin
                    pop = 1'b1;
                    case (q_head.kind)
                        sibl_pkg::K_SLOT_WR:
                        begin
                            slot_we = 1'b1;
                        end
                        sibl_pkg::K_RANGE_WR:
                        begin
                            range_we = 1'b1;
                        end
                        sibl_pkg::K_LOOKUP:
                        begin
                            range_re   = 1'b1;
                            pos_next   = q_head.arg0;
                            state_next = sibl_pkg::BK_RANGE;
                        end
                        default:
                        begin
                            res_next   = '0;
                            state_next = sibl_pkg::BK_DONE;
                        end
                    endcase
                end
            end
            sibl_pkg::BK_RANGE:
            begin
                if (!range_rd_reg.present || (range_rd_reg.first > range_rd_reg.last))
                begin
                    res_next   = '0;
                    state_next = sibl_pkg::BK_DONE;
                end
                else
                begin
                    lo_n       = range_rd_reg.first;
                    hi_n       = range_rd_reg.last;
                    probe      = 1'b1;
                    state_next = sibl_pkg::BK_PROBE;
                end
            end
            sibl_pkg::BK_PROBE:
            begin
                if ((probe_data.ibeg <= pos_reg) && (pos_reg <= probe_data.iend))
                begin
                    res_next.found      = 1'b1;
                    res_next.found_bin  = probe_data.ibin;
                    res_next.found_slot = mid_reg;
                    state_next          = sibl_pkg::BK_DONE;
                end
                else if (probe_data.ibeg > pos_reg)
                begin
                    // window empties when the probe sat on its low edge
                    if (mid_reg == lo_reg)
                    begin
                        res_next   = '0;
                        state_next = sibl_pkg::BK_DONE;
                    end
                    else
                    begin
                        hi_n  = mid_reg - 1'b1;
                        probe = 1'b1;
                    end
                end
                else
                begin
                    if (mid_reg == hi_reg)
                    begin
                        res_next   = '0;
                        state_next = sibl_pkg::BK_DONE;
                    end
                    else
                    begin
                        lo_n  = mid_reg + 1'b1;
                        probe = 1'b1;
                    end
                end
            end
            sibl_pkg::BK_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_next       = res_reg;
                    rsp_valid_next = 1'b1;
                    state_next     = sibl_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = sibl_pkg::BK_IDLE;
            end
        endcase

        lo_next  = lo_n;
        hi_next  = hi_n;
        mid_next = probe ? mid_n : mid_reg;
        oob_next = probe ? (32'(mid_n) >= 32'(TABLE_ENTRIES)) : oob_reg;
        slot_re  = probe && (32'(mid_n) < 32'(TABLE_ENTRIES));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sibl_pkg::BK_CLEAR;
            clr_cnt_reg   <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
        pos_reg <= pos_next;
        lo_reg  <= lo_next;
        hi_reg  <= hi_next;
        mid_reg <= mid_next;
        oob_reg <= oob_next;
        res_reg <= res_next;
    end

    always_ff @(posedge clk)
    begin
        if (slot_we)
        begin
            slot_mem[slot_waddr] <= {q_head.arg0, q_head.arg1, q_head.arg2};
        end
        if (slot_re)
        begin
            slot_rd_reg <= slot_mem[slot_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (range_we)
        begin
            range_mem[range_waddr] <= range_wdata;
        end
        if (range_re)
        begin
            range_rd_reg <= range_mem[range_raddr];
        end
    end

    assign status.clearing = (state_reg == sibl_pkg::BK_CLEAR);
    assign rsp_valid       = rsp_valid_reg;
    assign rsp             = rsp_reg;

    `SIBL_ASSERT_IMP(a_probe_in_window, state_reg == sibl_pkg::BK_PROBE,
        lo_reg <= mid_reg && mid_reg <= hi_reg, "probe outside search window")
    `SIBL_ASSERT_IMP(a_no_pop_clear, state_reg == sibl_pkg::BK_CLEAR, !pop,
        "queue popped during clearing pass")
    `SIBL_ASSERT_IMP(a_miss_zero, rsp_valid_reg && !rsp_reg.found,
        rsp_reg.found_bin == '0 && rsp_reg.found_slot == '0, "miss word not zeroed")
    `SIBL_ASSERT_NXT(a_result_out,
        state_reg == sibl_pkg::BK_DONE && (!rsp_valid_reg || !rsp_stall),
        rsp_valid_reg && state_reg == sibl_pkg::BK_IDLE, "finished lookup not presented")

endmodule

>>> sv/sorted_interval_binary_lookup.sv
// Channel | Dir | Payload               | Handshake
// req     | in  | sibl_pkg::req_word_t  | req_valid / req_stall
// rsp     | out | sibl_pkg::rsp_word_t  | rsp_valid / rsp_stall
//
// Top level of the sorted interval lookup: front, two-word queue, back.
// Depends on sibl_pkg, sibl_front, sibl_queue and sibl_back.
// Slot and range writes retire in the back end's idle state as they are popped from the queue.
// A lookup in the back end reads its range entry, then, for a present, ordered range, makes
// 1 to 13 binary search probes (4096 slots), one probe per cycle on the slot memory read port.
// After reset a clearing pass zeroes every range table entry;
// req_stall is high while it runs.
// Words wait in the queue while the back end searches; a stalled result holds
// the back end in its final state, so the queue fills and then req stalls.
module sorted_interval_binary_lookup #(
    parameter int TABLE_ENTRIES = sibl_pkg::TABLE_ENTRIES_DEF,
    parameter int NUM_CHROMS    = sibl_pkg::NUM_CHROMS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  sibl_pkg::req_word_t req,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output sibl_pkg::rsp_word_t rsp
);

    sibl_pkg::back_status_t status;
    sibl_pkg::work_t        push_data;
    sibl_pkg::work_t        q_head;
    logic                   push;
    logic                   pop;
    logic                   q_empty;
    logic                   q_full;

    sibl_front #(
        .TABLE_ENTRIES(TABLE_ENTRIES),
        .NUM_CHROMS   (NUM_CHROMS)
    ) u_front (
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req      (req),
        .status   (status),
        .q_full   (q_full),
        .push     (push),
        .push_data(push_data)
    );

    sibl_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_data(push_data),
        .pop      (pop),
        .head     (q_head),
        .empty    (q_empty),
        .full     (q_full)
    );

    sibl_back #(
        .TABLE_ENTRIES(TABLE_ENTRIES),
        .NUM_CHROMS   (NUM_CHROMS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_head   (q_head),
        .q_empty  (q_empty),
        .pop      (pop),
        .status   (status),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp      (rsp)
    );

endmodule

>>> dv/sibl_lookup_checker.sv
// Scoreboard for the sorted interval lookup: mirrors the slot and range tables,
// predicts the answer of every accepted lookup and compares each rsp word.
// Depends on sibl_pkg only.
module sibl_lookup_checker
    import sibl_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    input  logic      req_stall,
    input  req_word_t req,
    input  logic      rsp_valid,
    input  logic      rsp_stall,
    input  rsp_word_t rsp,
    output int        mismatches,
    output int        owed,
    output int        lookups,
    output int        hits
);

    logic [31:0] iv_begin [TABLE_ENTRIES_DEF];
    logic [31:0] iv_end   [TABLE_ENTRIES_DEF];
    logic [31:0] iv_bin   [TABLE_ENTRIES_DEF];
    logic [11:0] grp_lo   [NUM_CHROMS_DEF];
    logic [11:0] grp_hi   [NUM_CHROMS_DEF];
    bit          grp_on   [NUM_CHROMS_DEF];

    rsp_word_t answers_due [$];

    // binary search over the chromosome's slot group, truncating midpoint
    function automatic rsp_word_t search_table(input logic [7:0] chrom,
                                               input logic [31:0] pos);
        rsp_word_t ans;
        int lo;
        int hi;
        int mid;
        bit done;
        ans = '0;
        done = 1'b0;
        if (chrom < NUM_CHROMS_DEF && grp_on[chrom])
        begin
            lo = int'(grp_lo[chrom]);
            hi = int'(grp_hi[chrom]);
            while (!done && lo <= hi)
            begin
                mid = (lo + hi) / 2;
                if (iv_begin[mid] <= pos && pos <= iv_end[mid])
                begin
                    ans.found = 1'b1;
                    ans.found_bin = iv_bin[mid];
                    ans.found_slot = 12'(mid);
                    done = 1'b1;
                end
                else if (iv_begin[mid] > pos)
                    hi = mid - 1;
                else
                    lo = mid + 1;
            end
        end
        return ans;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        rsp_word_t want;
        if (!rst_n)
        begin
            for (int c = 0; c < NUM_CHROMS_DEF; c++)
                grp_on[c] = 1'b0;
            answers_due.delete();
            mismatches = 0;
            lookups = 0;
            hits = 0;
        end
        else
        begin
            if (rsp_valid === 1'b1 && rsp_stall === 1'b0)
            begin
                if (answers_due.size() == 0)
                begin
                    $display("%0t rsp word with none expected: found=%0b bin=%h slot=%h",
                             $time, rsp.found, rsp.found_bin, rsp.found_slot);
                    mismatches++;
                end
                else
                begin
                    want = answers_due.pop_front();
                    if (rsp.found !== want.found)
                    begin
                        $display("%0t found: expected %0b, got %0b",
                                 $time, want.found, rsp.found);
                        mismatches++;
                    end
                    if (rsp.found_bin !== want.found_bin)
                    begin
                        $display("%0t found_bin: expected %h, got %h",
                                 $time, want.found_bin, rsp.found_bin);
                        mismatches++;
                    end
                    if (rsp.found_slot !== want.found_slot)
                    begin
                        $display("%0t found_slot: expected %h, got %h",
                                 $time, want.found_slot, rsp.found_slot);
                        mismatches++;
                    end
                    if (want.found)
                        hits++;
                end
            end
            if (req_valid === 1'b1 && req_stall === 1'b0)
            begin
                case (req.opcode)
                    OP_SLOT_WR:
                    begin
                        if (req.slot < TABLE_ENTRIES_DEF)
                        begin
                            iv_begin[req.slot] = req.interval_begin;
                            iv_end[req.slot] = req.interval_end;
                            iv_bin[req.slot] = req.bin_number;
                        end
                    end
                    OP_RANGE_WR:
                    begin
                        // range is stored whatever the present bit says
                        if (req.chrom < NUM_CHROMS_DEF)
                        begin
                            grp_lo[req.chrom] = req.range_first;
                            grp_hi[req.chrom] = req.range_last;
                            grp_on[req.chrom] = req.chrom_present;
                        end
                    end
                    OP_LOOKUP:
                    begin
                        answers_due.insert(answers_due.size(),
                                           search_table(req.chrom, req.position));
                        lookups++;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
        owed = answers_due.size();
    end

endmodule

>>> dv/tb.sv
// Stimulus top for sorted_interval_binary_lookup: loads sorted interval groups,
// runs lookups under changing idle and stall mixes and gives the verdict.
// Depends on sibl_pkg, the block and sibl_lookup_checker.
module tb;
    import sibl_pkg::*;

    localparam int         ITEM_BUDGET = 1700;
    localparam int         QUIET_LIMIT = 2000;
    localparam int         HOLD_LEN    = 80;
    localparam int         TAIL_CYCLES = 40;
    localparam logic [1:0] OP_UNUSED   = 2'd3;

    logic      clk;
    logic      rst_n = 1'b0;
    logic      req_valid = 1'b0;
    logic      req_stall;
    req_word_t req = '0;
    logic      rsp_valid;
    logic      rsp_stall = 1'b0;
    rsp_word_t rsp;

    int mismatches;
    int owed;
    int lookups;
    int hits;

    int send_idle_pct = 0;
    int stall_pct = 0;
    int hold_asked = 0;
    int sent = 0;

    // slots written so far; a present range may only cover these
    bit          slot_loaded [TABLE_ENTRIES_DEF];
    logic [31:0] cur_begin [256];
    logic [31:0] cur_end   [256];

    sorted_interval_binary_lookup uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    sibl_lookup_checker chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req        (req),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .rsp        (rsp),
        .mismatches (mismatches),
        .owed       (owed),
        .lookups    (lookups),
        .hits       (hits)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic req_word_t noise_word();
        req_word_t w;
        w.opcode = 2'($urandom_range(2));
        w.chrom = 8'($urandom);
        w.slot = 12'($urandom);
        w.interval_begin = $urandom;
        w.interval_end = $urandom;
        w.bin_number = $urandom;
        w.range_first = 12'($urandom);
        w.range_last = 12'($urandom);
        w.chrom_present = 1'($urandom);
        w.position = $urandom;
        return w;
    endfunction

    function automatic bit span_loaded(input int lo, input int hi);
        for (int i = lo; i <= hi; i++)
            if (!slot_loaded[i])
                return 1'b0;
        return 1'b1;
    endfunction

    task automatic push_word(input req_word_t w);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= w;
        @(posedge clk);
        while (req_stall !== 1'b0)
            @(posedge clk);
        if (w.opcode != OP_UNUSED)
            sent++;
    endtask

    task automatic load_slot(input logic [11:0] s, input logic [31:0] b,
                             input logic [31:0] e, input logic [31:0] bin);
        req_word_t w;
        w = noise_word();
        w.opcode = OP_SLOT_WR;
        w.slot = s;
        w.interval_begin = b;
        w.interval_end = e;
        w.bin_number = bin;
        slot_loaded[s] = 1'b1;
        push_word(w);
    endtask

    task automatic set_range(input logic [7:0] c, input logic [11:0] lo,
                             input logic [11:0] hi, input logic on);
        req_word_t w;
        w = noise_word();
        w.opcode = OP_RANGE_WR;
        w.chrom = c;
        w.range_first = lo;
        w.range_last = hi;
        w.chrom_present = on;
        push_word(w);
    endtask

    task automatic look_up(input logic [7:0] c, input logic [31:0] pos);
        req_word_t w;
        w = noise_word();
        w.opcode = OP_LOOKUP;
        w.chrom = c;
        w.position = pos;
        push_word(w);
    endtask

    // drop valid and wait until every lookup answer is back
    task automatic drain();
        req_valid <= 1'b0;
        @(posedge clk);
        while (owed != 0)
            @(posedge clk);
    endtask

    task automatic noise_item();
        req_word_t w;
        int lo;
        int hi;
        case ($urandom_range(3))
            0:
            begin
                w = noise_word();
                w.opcode = OP_UNUSED;
                push_word(w);
            end
            1: look_up(8'($urandom), $urandom);
            2:
            begin
                lo = $urandom_range(4095);
                if ($urandom_range(3) == 0)
                    hi = $urandom_range(4095);
                else
                begin
                    hi = lo + $urandom_range(24);
                    if (hi > 4095)
                        hi = 4095;
                end
                set_range(8'($urandom), 12'(lo), 12'(hi),
                          span_loaded(lo, hi) ? 1'($urandom) : 1'b0);
            end
            default: load_slot(12'($urandom), $urandom, $urandom, $urandom);
        endcase
    endtask

    function automatic logic [31:0] pick_position(input int n);
        int i;
        logic [31:0] pos;
        i = $urandom_range(n - 1);
        case ($urandom_range(5))
            0: pos = cur_begin[i];
            1: pos = cur_end[i];
            2: pos = cur_begin[i] + $urandom_range(cur_end[i] - cur_begin[i]);
            3: pos = cur_end[i] + 32'd1;
            4: pos = cur_begin[i] - 32'd1;
            default: pos = $urandom;
        endcase
        return pos;
    endfunction

    // one chromosome: sorted, disjoint intervals loaded in shuffled order,
    // then its range, then lookups into hits, edges and gaps, with noise items mixed in
    task automatic run_group();
        int n;
        int base;
        int i;
        int j;
        int tmp;
        int seq [256];
        longint step;
        longint span;
        longint cur;
        longint b;
        longint e;
        logic [31:0] r32;
        logic [7:0] c;
        n = ($urandom_range(19) == 0) ? $urandom_range(64, 200) : $urandom_range(1, 12);
        base = $urandom_range(TABLE_ENTRIES_DEF - n);
        step = longint'(1) << $urandom_range(24);
        while (longint'(n) * (2 * step + 2) >= 64'h1_0000_0000)
            step = step >> 1;
        span = longint'(n) * (2 * step + 2);
        r32 = $urandom;
        case ($urandom_range(7))
            0: cur = 0;
            1: cur = 64'h1_0000_0000 - span;
            default: cur = r32 % (64'h1_0000_0000 - span);
        endcase
        for (i = 0; i < n; i++)
        begin
            b = cur + $urandom_range(32'(step));
            e = b + $urandom_range(32'(step));
            cur_begin[i] = 32'(b);
            cur_end[i] = 32'(e);
            cur = e + 1;
            seq[i] = i;
        end
        for (i = n - 1; i > 0; i--)
        begin
            j = $urandom_range(i);
            tmp = seq[i];
            seq[i] = seq[j];
            seq[j] = tmp;
        end
        for (i = 0; i < n; i++)
            load_slot(12'(base + seq[i]), cur_begin[seq[i]], cur_end[seq[i]], $urandom);
        c = 8'($urandom);
        set_range(c, 12'(base), 12'(base + n - 1), $urandom_range(7) != 0);
        repeat (n + $urandom_range(2, 8))
        begin
            if ($urandom_range(7) == 0)
                noise_item();
            else
                look_up(c, pick_position(n));
        end
    endtask

    // long hold on rsp on request, random stalls otherwise
    initial
    begin : receiver
        int hold_left;
        int hold_taken;
        hold_left = 0;
        hold_taken = 0;
        forever
        begin
            @(posedge clk);
            if (hold_left == 0 && hold_taken != hold_asked)
            begin
                hold_taken++;
                hold_left = HOLD_LEN;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_stall <= 1'b1;
            end
            else
                rsp_stall <= stall_pct != 0 && $urandom_range(99) < stall_pct;
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((req_valid && req_stall === 1'b0) || (rsp_valid === 1'b1 && !rsp_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t no word moved for %0d cycles", $time, QUIET_LIMIT);
        $display("status: fail");
        $finish;
    end

    initial
    begin : stim
        int phase;
        int prev_phase;
        req_word_t w;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        look_up(8'd0, 32'd0);                   // nothing present after reset
        load_slot(12'd0, 32'd0, 32'd10, '1);
        load_slot(12'd1, 32'd20, 32'd30, 32'd0);
        load_slot(12'd2, 32'd40, 32'd40, 32'h5A5A_5A5A);
        load_slot(12'd3, 32'd100, '1, 32'hA5A5_A5A5);
        set_range(8'd0, 12'd0, 12'd3, 1'b1);
        look_up(8'd0, 32'd0);
        look_up(8'd0, 32'd10);                  // end is inclusive
        look_up(8'd0, 32'd15);                  // gap between intervals
        look_up(8'd0, 32'd40);
        look_up(8'd0, '1);
        look_up(8'd0, 32'd50);
        set_range(8'hFF, 12'd3, 12'd0, 1'b1);   // inverted range
        look_up(8'hFF, 32'd20);
        set_range(8'd0, 12'd0, 12'd3, 1'b0);    // chromosome cleared
        look_up(8'd0, 32'd20);
        set_range(8'd0, 12'd0, 12'd3, 1'b1);
        load_slot(12'hFFF, 32'd5, 32'd5, 32'h1234_5678);
        set_range(8'd1, 12'hFFF, 12'hFFF, 1'b1);
        look_up(8'd1, 32'd5);
        look_up(8'd1, 32'd6);
        w = noise_word();
        w.opcode = OP_UNUSED;
        push_word(w);

        prev_phase = 0;
        while (sent < ITEM_BUDGET)
        begin
            phase = sent * 5 / ITEM_BUDGET;
            if (phase != prev_phase)
            begin
                drain();
                prev_phase = phase;
                case (phase)
                    1:
                    begin
                        send_idle_pct = 53;
                        stall_pct = 0;
                    end
                    2:
                    begin
                        send_idle_pct = 0;
                        stall_pct = 53;
                        // rsp held off while lookups keep coming: fills the block
                        hold_asked++;
                        repeat (8) look_up(8'($urandom_range(2)), $urandom);
                    end
                    3:
                    begin
                        send_idle_pct = 26;
                        stall_pct = 26;
                    end
                    default:
                    begin
                        send_idle_pct = 0;
                        stall_pct = 0;
                    end
                endcase
            end
            run_group();
        end
        drain();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d words, %0d lookups checked, %0d of them hits,", sent, lookups, hits);
        $display("under no idling, sender gaps, rsp stalls, both, and one long rsp hold");
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
